FILE: hw/rtl/assert_macros.svh
// assertion macros for the checker file d2q9_chk.sv
// each macro expects clk and rst_n in scope
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition must never hold outside reset
`define D2Q9_ASSERT_NEVER(lbl, c) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(c)) \
        else $error("d2q9 check failed: forbidden condition seen");

// same-cycle implication
`define D2Q9_ASSERT_IMPLY(lbl, a, c) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
        else $error("d2q9 check failed: implication broken");

// implication a fixed number of cycles later
`define D2Q9_ASSERT_AFTER(lbl, a, n, c) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> ##n (c)) \
        else $error("d2q9 check failed: delayed implication broken");

`endif

FILE: hw/rtl/d2q9_pkg.sv
// shared constants and types for the d2q9 bgk collision core
// no dependencies
`timescale 1ns / 1ps

package d2q9_pkg;

    localparam int NUM_POP    = 9;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 30;
    localparam int RELAX_W    = 30;
    localparam int WEIGHT_W   = 29;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_RELAX_RATE,
        REG_WEIGHT_REST,
        REG_WEIGHT_AXIS,
        REG_WEIGHT_DIAG
    } cfg_reg_t;

endpackage

FILE: hw/rtl/d2q9_bgk_collision_core.sv
// d2q9 bgk collision core: one lattice node per item, fully pipelined
// throughput one item per clock; the divider adds one stage per quotient bit
// busy is never raised; results appear on done for one cycle and cannot stall
// rst_n is asynchronous: clears the valid pipeline and presets the configuration registers
// uses d2q9_pkg, d2q9_sat, d2q9_dly, d2q9_mulr, d2q9_div
`timescale 1ns / 1ps

module d2q9_bgk_collision_core #(
    parameter int WORD_WIDTH = 32,
    parameter int FRAC_BITS  = 28
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    output logic                                busy,
    output logic                                done,
    input  logic                                wr_en,
    input  logic [d2q9_pkg::CFG_IDX_W-1:0]      wr_index,
    input  logic [d2q9_pkg::CFG_DATA_W-1:0]     wr_data,
    input  logic signed [WORD_WIDTH-1:0]        pop_in_0,
    input  logic signed [WORD_WIDTH-1:0]        pop_in_1,
    input  logic signed [WORD_WIDTH-1:0]        pop_in_2,
    input  logic signed [WORD_WIDTH-1:0]        pop_in_3,
    input  logic signed [WORD_WIDTH-1:0]        pop_in_4,
    input  logic signed [WORD_WIDTH-1:0]        pop_in_5,
    input  logic signed [WORD_WIDTH-1:0]        pop_in_6,
    input  logic signed [WORD_WIDTH-1:0]        pop_in_7,
    input  logic signed [WORD_WIDTH-1:0]        pop_in_8,
    output logic signed [WORD_WIDTH-1:0]        pop_out_0,
    output logic signed [WORD_WIDTH-1:0]        pop_out_1,
    output logic signed [WORD_WIDTH-1:0]        pop_out_2,
    output logic signed [WORD_WIDTH-1:0]        pop_out_3,
    output logic signed [WORD_WIDTH-1:0]        pop_out_4,
    output logic signed [WORD_WIDTH-1:0]        pop_out_5,
    output logic signed [WORD_WIDTH-1:0]        pop_out_6,
    output logic signed [WORD_WIDTH-1:0]        pop_out_7,
    output logic signed [WORD_WIDTH-1:0]        pop_out_8,
    output logic signed [WORD_WIDTH-1:0]        density,
    output logic signed [WORD_WIDTH-1:0]        vel_x,
    output logic signed [WORD_WIDTH-1:0]        vel_y
);

    import d2q9_pkg::*;

    localparam int W   = WORD_WIDTH;
    localparam int SW  = W + 4;    // nine-way sum
    localparam int EW  = W + 8;    // equilibrium factor sum
    localparam int LAT = W + 14;   // start to done

    // register presets: 1.0, 4/9, 1/9, 1/36 rounded to nearest
    localparam logic [63:0] ONE_Q      = 64'd1 << FRAC_BITS;
    localparam logic [63:0] RST_W_REST = (ONE_Q * 64'd4 + 64'd4) / 64'd9;
    localparam logic [63:0] RST_W_AXIS = (ONE_Q + 64'd4) / 64'd9;
    localparam logic [63:0] RST_W_DIAG = (ONE_Q + 64'd18) / 64'd36;

    // doubled constant term of the equilibrium factor (2.0)
    localparam logic signed [EW-1:0] DTWO = EW'(1) << (FRAC_BITS + 1);

    // ------------------------------------------------------------------
    // configuration registers: the user writes them only while the pipe is empty (not enforced)
    // ------------------------------------------------------------------
    logic [RELAX_W-1:0]  relax_reg;
    logic [WEIGHT_W-1:0] weight_rest_reg;
    logic [WEIGHT_W-1:0] weight_axis_reg;
    logic [WEIGHT_W-1:0] weight_diag_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            relax_reg       <= ONE_Q[RELAX_W-1:0];
            weight_rest_reg <= RST_W_REST[WEIGHT_W-1:0];
            weight_axis_reg <= RST_W_AXIS[WEIGHT_W-1:0];
            weight_diag_reg <= RST_W_DIAG[WEIGHT_W-1:0];
        end
        else if (wr_en)
        begin
            case (cfg_reg_t'(wr_index))
                REG_RELAX_RATE:  relax_reg       <= wr_data[RELAX_W-1:0];
                REG_WEIGHT_REST: weight_rest_reg <= wr_data[WEIGHT_W-1:0];
                REG_WEIGHT_AXIS: weight_axis_reg <= wr_data[WEIGHT_W-1:0];
                REG_WEIGHT_DIAG: weight_diag_reg <= wr_data[WEIGHT_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    // ------------------------------------------------------------------
    // handshake and valid pipeline; a new item may enter every cycle
    // ------------------------------------------------------------------
    logic           accept;
    logic [LAT-1:0] valid_reg;
    logic [LAT-1:0] valid_next;

    assign busy       = 1'b0;
    assign accept     = start && !busy;
    assign valid_next = {valid_reg[LAT-2:0], accept};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    assign done = valid_reg[LAT-1];

    // ------------------------------------------------------------------
    // stage 1: capture the node
    // ------------------------------------------------------------------
    logic [NUM_POP-1:0][W-1:0] p_s0_reg;
    logic [NUM_POP-1:0][W-1:0] p_s1_reg;

    always_ff @(posedge clk)
    begin
        p_s0_reg <= {pop_in_8, pop_in_7, pop_in_6, pop_in_5, pop_in_4,
                     pop_in_3, pop_in_2, pop_in_1, pop_in_0};
    end

    // ------------------------------------------------------------------
    // stage 2: density and momenta, exact then saturated
    // ------------------------------------------------------------------
    logic signed [SW-1:0] pe [NUM_POP];
    logic signed [SW-1:0] rho_sum;
    logic signed [SW-1:0] mx_sum;
    logic signed [SW-1:0] my_sum;
    logic signed [W-1:0]  rho_next;
    logic signed [W-1:0]  mx_next;
    logic signed [W-1:0]  my_next;
    logic signed [W-1:0]  rho_reg;
    logic signed [W-1:0]  mx_reg;
    logic signed [W-1:0]  my_reg;
    logic                 rho_pos;

    always_comb
    begin
        for (int i = 0; i < NUM_POP; i++)
        begin
            pe[i] = SW'($signed(p_s0_reg[i]));
        end
        rho_sum = '0;
        for (int i = 0; i < NUM_POP; i++)
        begin
            rho_sum = rho_sum + pe[i];
        end
        mx_sum = pe[1] + pe[5] + pe[8] - pe[3] - pe[6] - pe[7];
        my_sum = pe[2] + pe[5] + pe[6] - pe[4] - pe[7] - pe[8];
    end

    d2q9_sat #(.IW(SW), .OW(W)) u_sat_rho (.din(rho_sum), .dout(rho_next));
    d2q9_sat #(.IW(SW), .OW(W)) u_sat_mx  (.din(mx_sum),  .dout(mx_next));
    d2q9_sat #(.IW(SW), .OW(W)) u_sat_my  (.din(my_sum),  .dout(my_next));

    always_ff @(posedge clk)
    begin
        rho_reg  <= rho_next;
        mx_reg   <= mx_next;
        my_reg   <= my_next;
        p_s1_reg <= p_s0_reg;
    end

    // non-positive density gives zero velocity via the divider's gate
    assign rho_pos = !rho_reg[W-1] && (rho_reg != '0);

    // ------------------------------------------------------------------
    // velocity: two bit-per-stage dividers
    // ------------------------------------------------------------------
    logic signed [W-1:0] ux_q;
    logic signed [W-1:0] uy_q;

    d2q9_div #(.W(W), .F(FRAC_BITS)) u_div_x (
        .clk (clk),
        .num (mx_reg),
        .den (rho_reg),
        .pos (rho_pos),
        .quo (ux_q)
    );

    d2q9_div #(.W(W), .F(FRAC_BITS)) u_div_y (
        .clk (clk),
        .num (my_reg),
        .den (rho_reg),
        .pos (rho_pos),
        .quo (uy_q)
    );

    // weighted density for the three weight classes, aligned to the d stage
    logic signed [W-1:0]   wrho_rest;
    logic signed [W-1:0]   wrho_axis;
    logic signed [W-1:0]   wrho_diag;
    logic [3*W-1:0]        wrho_dly;
    logic signed [W-1:0]   wrho_al [3];

    d2q9_mulr #(.AW(WEIGHT_W+1), .BW(W), .SH(FRAC_BITS), .OW(W)) u_mul_wr (
        .clk (clk), .a ($signed({1'b0, weight_rest_reg})), .b (rho_reg), .y (wrho_rest)
    );
    d2q9_mulr #(.AW(WEIGHT_W+1), .BW(W), .SH(FRAC_BITS), .OW(W)) u_mul_wa (
        .clk (clk), .a ($signed({1'b0, weight_axis_reg})), .b (rho_reg), .y (wrho_axis)
    );
    d2q9_mulr #(.AW(WEIGHT_W+1), .BW(W), .SH(FRAC_BITS), .OW(W)) u_mul_wd (
        .clk (clk), .a ($signed({1'b0, weight_diag_reg})), .b (rho_reg), .y (wrho_diag)
    );

    d2q9_dly #(.WIDTH(3*W), .DEPTH(W+4)) u_dly_wrho (
        .clk  (clk),
        .din  ({wrho_diag, wrho_axis, wrho_rest}),
        .dout (wrho_dly)
    );

    assign wrho_al[0] = wrho_dly[W-1:0];
    assign wrho_al[1] = wrho_dly[2*W-1:W];
    assign wrho_al[2] = wrho_dly[3*W-1:2*W];

    // ------------------------------------------------------------------
    // velocity products, then usq
    // ------------------------------------------------------------------
    logic signed [W-1:0] sx;
    logic signed [W-1:0] sy;
    logic signed [W-1:0] sxy;
    logic [2*W-1:0]      u_dly;

    d2q9_mulr #(.AW(W), .BW(W), .SH(FRAC_BITS), .OW(W)) u_mul_sx (
        .clk (clk), .a (ux_q), .b (ux_q), .y (sx)
    );
    d2q9_mulr #(.AW(W), .BW(W), .SH(FRAC_BITS), .OW(W)) u_mul_sy (
        .clk (clk), .a (uy_q), .b (uy_q), .y (sy)
    );
    d2q9_mulr #(.AW(W), .BW(W), .SH(FRAC_BITS), .OW(W)) u_mul_sxy (
        .clk (clk), .a (ux_q), .b (uy_q), .y (sxy)
    );

    d2q9_dly #(.WIDTH(2*W), .DEPTH(2)) u_dly_u (
        .clk (clk), .din ({uy_q, ux_q}), .dout (u_dly)
    );

    logic signed [W:0]   usq_sum;
    logic signed [W-1:0] usq_next;
    logic signed [W-1:0] usq_reg;
    logic signed [W-1:0] ux_u_reg;
    logic signed [W-1:0] uy_u_reg;
    logic signed [W-1:0] sx_u_reg;
    logic signed [W-1:0] sy_u_reg;
    logic signed [W-1:0] sxy_u_reg;

    assign usq_sum = (W+1)'(sx) + (W+1)'(sy);

    d2q9_sat #(.IW(W+1), .OW(W)) u_sat_usq (.din(usq_sum), .dout(usq_next));

    always_ff @(posedge clk)
    begin
        usq_reg   <= usq_next;
        ux_u_reg  <= u_dly[W-1:0];
        uy_u_reg  <= u_dly[2*W-1:W];
        sx_u_reg  <= sx;
        sy_u_reg  <= sy;
        sxy_u_reg <= sxy;
    end

    // ------------------------------------------------------------------
    // doubled equilibrium factor per channel, small constants as shifts
    // ------------------------------------------------------------------
    logic signed [EW-1:0] ux_e, uy_e, sx_e, sy_e, sxy_e, usq_e;
    logic signed [EW-1:0] ux6, uy6, sx9, sy9, sxy18, usq3, usq6;
    logic signed [EW-1:0] d_sum [NUM_POP];
    logic signed [W-1:0]  d_next [NUM_POP];
    logic signed [W-1:0]  d_reg [NUM_POP];

    always_comb
    begin
        ux_e  = EW'(ux_u_reg);
        uy_e  = EW'(uy_u_reg);
        sx_e  = EW'(sx_u_reg);
        sy_e  = EW'(sy_u_reg);
        sxy_e = EW'(sxy_u_reg);
        usq_e = EW'(usq_reg);
        ux6   = (ux_e <<< 2) + (ux_e <<< 1);
        uy6   = (uy_e <<< 2) + (uy_e <<< 1);
        sx9   = (sx_e <<< 3) + sx_e;
        sy9   = (sy_e <<< 3) + sy_e;
        sxy18 = (sxy_e <<< 4) + (sxy_e <<< 1);
        usq3  = (usq_e <<< 1) + usq_e;
        usq6  = usq3 <<< 1;
        // rest, then axis channels, then diagonals
        d_sum[0] = DTWO - usq3;
        d_sum[1] = DTWO + ux6 + sx9 - usq3;
        d_sum[2] = DTWO + uy6 + sy9 - usq3;
        d_sum[3] = DTWO - ux6 + sx9 - usq3;
        d_sum[4] = DTWO - uy6 + sy9 - usq3;
        d_sum[5] = DTWO + ux6 + uy6 + sxy18 + usq6;
        d_sum[6] = DTWO - ux6 + uy6 - sxy18 + usq6;
        d_sum[7] = DTWO - ux6 - uy6 + sxy18 + usq6;
        d_sum[8] = DTWO + ux6 - uy6 - sxy18 + usq6;
    end

    // velocity carried to the output stage
    logic [2*W-1:0] vel_dly;

    d2q9_dly #(.WIDTH(2*W), .DEPTH(6)) u_dly_vel (
        .clk (clk), .din ({uy_u_reg, ux_u_reg}), .dout (vel_dly)
    );

    // density carried to the output stage
    logic [W-1:0] rho_dly;

    d2q9_dly #(.WIDTH(W), .DEPTH(W+11)) u_dly_rho (
        .clk (clk), .din (rho_reg), .dout (rho_dly)
    );

    // populations carried to the difference and output stages
    logic [NUM_POP-1:0][W-1:0] p_a;
    logic [NUM_POP-1:0][W-1:0] p_b;

    d2q9_dly #(.WIDTH(NUM_POP*W), .DEPTH(W+8)) u_dly_pa (
        .clk (clk), .din (p_s1_reg), .dout (p_a)
    );

    d2q9_dly #(.WIDTH(NUM_POP*W), .DEPTH(3)) u_dly_pb (
        .clk (clk), .din (p_a), .dout (p_b)
    );

    // ------------------------------------------------------------------
    // per-channel relaxation: eq, diff, omega*diff, output
    // ------------------------------------------------------------------
    logic signed [W-1:0] eq      [NUM_POP];
    logic signed [W-1:0] diff_next [NUM_POP];
    logic signed [W-1:0] diff_reg  [NUM_POP];
    logic signed [W-1:0] rel     [NUM_POP];
    logic signed [W-1:0] out_next  [NUM_POP];
    logic signed [W-1:0] pop_out_reg [NUM_POP];

    for (genvar i = 0; i < NUM_POP; i++)
    begin : g_chan
        localparam int WSEL = (i == 0) ? 0 : ((i <= 4) ? 1 : 2);

        logic signed [EW-1:0] dsat_in;
        logic signed [W:0]    dif_sum;
        logic signed [W:0]    out_sum;

        assign dsat_in = d_sum[i];

        d2q9_sat #(.IW(EW), .OW(W)) u_sat_d (.din(dsat_in), .dout(d_next[i]));

        always_ff @(posedge clk)
        begin
            d_reg[i] <= d_next[i];
        end

        d2q9_mulr #(.AW(W), .BW(W), .SH(FRAC_BITS+1), .OW(W)) u_mul_eq (
            .clk (clk), .a (wrho_al[WSEL]), .b (d_reg[i]), .y (eq[i])
        );

        assign dif_sum = (W+1)'($signed(p_a[i])) - (W+1)'(eq[i]);

        d2q9_sat #(.IW(W+1), .OW(W)) u_sat_dif (.din(dif_sum), .dout(diff_next[i]));

        always_ff @(posedge clk)
        begin
            diff_reg[i] <= diff_next[i];
        end

        d2q9_mulr #(.AW(RELAX_W+1), .BW(W), .SH(FRAC_BITS), .OW(W)) u_mul_rel (
            .clk (clk), .a ($signed({1'b0, relax_reg})), .b (diff_reg[i]), .y (rel[i])
        );

        assign out_sum = (W+1)'($signed(p_b[i])) - (W+1)'(rel[i]);

        d2q9_sat #(.IW(W+1), .OW(W)) u_sat_out (.din(out_sum), .dout(out_next[i]));

        always_ff @(posedge clk)
        begin
            pop_out_reg[i] <= out_next[i];
        end
    end

    // ------------------------------------------------------------------
    // output registers for the scalar fields
    // ------------------------------------------------------------------
    logic signed [W-1:0] density_reg;
    logic signed [W-1:0] vel_x_reg;
    logic signed [W-1:0] vel_y_reg;

    always_ff @(posedge clk)
    begin
        density_reg <= rho_dly;
        vel_x_reg   <= vel_dly[W-1:0];
        vel_y_reg   <= vel_dly[2*W-1:W];
    end

    assign pop_out_0 = pop_out_reg[0];
    assign pop_out_1 = pop_out_reg[1];
    assign pop_out_2 = pop_out_reg[2];
    assign pop_out_3 = pop_out_reg[3];
    assign pop_out_4 = pop_out_reg[4];
    assign pop_out_5 = pop_out_reg[5];
    assign pop_out_6 = pop_out_reg[6];
    assign pop_out_7 = pop_out_reg[7];
    assign pop_out_8 = pop_out_reg[8];
    assign density   = density_reg;
    assign vel_x     = vel_x_reg;
    assign vel_y     = vel_y_reg;

endmodule

FILE: hw/rtl/d2q9_sat.sv
// signed saturation from a wide sum down to a word
// no dependencies
`timescale 1ns / 1ps

module d2q9_sat #(
    parameter int IW = 36,
    parameter int OW = 32
) (
    input  logic signed [IW-1:0] din,
    output logic signed [OW-1:0] dout
);

    logic [IW-OW:0] hi;

    assign hi = din[IW-1:OW-1];

    always_comb
    begin
        if ((&hi) || !(|hi))
        begin
            dout = din[OW-1:0];
        end
        else if (din[IW-1])
        begin
            dout = {1'b1, {(OW-1){1'b0}}};
        end
        else
        begin
            dout = {1'b0, {(OW-1){1'b1}}};
        end
    end

endmodule

FILE: hw/rtl/d2q9_dly.sv
// fixed-depth register delay line for payload
// no dependencies
`timescale 1ns / 1ps

module d2q9_dly #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 2
) (
    input  logic             clk,
    input  logic [WIDTH-1:0] din,
    output logic [WIDTH-1:0] dout
);

    logic [WIDTH-1:0] tap_reg [DEPTH];

    always_ff @(posedge clk)
    begin
        tap_reg[0] <= din;
        for (int k = 1; k < DEPTH; k++)
        begin
            tap_reg[k] <= tap_reg[k-1];
        end
    end

    assign dout = tap_reg[DEPTH-1];

endmodule

FILE: hw/rtl/d2q9_mulr.sv
// two-stage signed multiplier with round-half-away shift and saturation
// no dependencies
`timescale 1ns / 1ps

module d2q9_mulr #(
    parameter int AW = 32,
    parameter int BW = 32,
    parameter int SH = 28,
    parameter int OW = 32
) (
    input  logic                 clk,
    input  logic signed [AW-1:0] a,
    input  logic signed [BW-1:0] b,
    output logic signed [OW-1:0] y
);

    localparam int PW = AW + BW;
    localparam logic [PW:0] HALF = (PW+1)'(1) << (SH - 1);
    localparam logic [PW:0] QMAX = (PW+1)'({(OW-1){1'b1}});
    localparam logic [PW:0] QNEG = QMAX + (PW+1)'(1);

    logic signed [PW-1:0] prod_reg;
    logic                 neg;
    logic [PW-1:0]        mag;
    logic [PW:0]          rsum;
    logic [PW:0]          q;
    logic [OW-1:0]        qneg;
    logic signed [OW-1:0] y_next;
    logic signed [OW-1:0] y_reg;

    always_ff @(posedge clk)
    begin
        prod_reg <= a * b;
    end

    always_comb
    begin
        neg  = prod_reg[PW-1];
        mag  = neg ? PW'(-prod_reg) : PW'(prod_reg);
        rsum = {1'b0, mag} + HALF;
        q    = rsum >> SH;
        qneg = ~q[OW-1:0] + 1'b1;
        if (neg)
        begin
            y_next = (q > QNEG) ? {1'b1, {(OW-1){1'b0}}} : qneg;
        end
        else
        begin
            y_next = (q > QMAX) ? {1'b0, {(OW-1){1'b1}}} : q[OW-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        y_reg <= y_next;
    end

    assign y = y_reg;

endmodule

FILE: hw/rtl/d2q9_div.sv
// pipelined restoring divider: num * 2^F / den, truncated, saturated
// one quotient bit per stage; no dependencies
`timescale 1ns / 1ps

module d2q9_div #(
    parameter int W = 32,
    parameter int F = 28
) (
    input  logic                clk,
    input  logic signed [W-1:0] num,
    input  logic signed [W-1:0] den,
    input  logic                pos,
    output logic signed [W-1:0] quo
);

    localparam logic [W-1:0] QMAX = {1'b0, {(W-1){1'b1}}};
    localparam logic [W-1:0] QNEG = {1'b1, {(W-1){1'b0}}};

    logic [W-1:0] mag;
    logic [W-1:0] dd;
    logic [W-1:0] mm;
    logic [W-1:0] hiw;
    logic [W-1:0] lo0;
    logic         ovf0;
    logic         neg0;

    logic [W-1:0] rem_reg [W+1];
    logic [W-1:0] lo_reg  [W+1];
    logic [W-1:0] q_reg   [W+1];
    logic [W-1:0] d_reg   [W+1];
    logic         ovf_reg [W+1];
    logic         neg_reg [W+1];
    logic signed [W-1:0] quo_next;
    logic signed [W-1:0] quo_reg;

    // magnitude split: top part seeds the remainder, low part is shifted in
    always_comb
    begin
        mag  = num[W-1] ? W'(-num) : W'(num);
        dd   = pos ? W'(den) : W'(1);
        mm   = pos ? mag : '0;
        hiw  = mm >> (W - F);
        ovf0 = (hiw >= dd);
        lo0  = mm << F;
        neg0 = pos & num[W-1];
    end

    always_ff @(posedge clk)
    begin
        rem_reg[0] <= hiw;
        lo_reg[0]  <= lo0;
        q_reg[0]   <= '0;
        d_reg[0]   <= dd;
        ovf_reg[0] <= ovf0;
        neg_reg[0] <= neg0;
    end

    for (genvar k = 0; k < W; k++)
    begin : g_step
        logic [W:0] trial;
        logic [W:0] tdiff;
        logic       ge;

        always_comb
        begin
            trial = {rem_reg[k], lo_reg[k][W-1]};
            tdiff = trial - {1'b0, d_reg[k]};
            ge    = (trial >= {1'b0, d_reg[k]});
        end

        always_ff @(posedge clk)
        begin
            rem_reg[k+1] <= ge ? tdiff[W-1:0] : trial[W-1:0];
            lo_reg[k+1]  <= lo_reg[k] << 1;
            q_reg[k+1]   <= {q_reg[k][W-2:0], ge};
            d_reg[k+1]   <= d_reg[k];
            ovf_reg[k+1] <= ovf_reg[k];
            neg_reg[k+1] <= neg_reg[k];
        end
    end

    always_comb
    begin
        if (neg_reg[W])
        begin
            quo_next = (ovf_reg[W] || (q_reg[W] > QNEG)) ? QNEG : W'(-q_reg[W]);
        end
        else
        begin
            quo_next = (ovf_reg[W] || (q_reg[W] > QMAX)) ? QMAX : q_reg[W];
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
    end

    assign quo = quo_reg;

endmodule

FILE: hw/rtl/d2q9_chk.sv
// port-level checker for the d2q9 collision core, bound to the top level
// depends on assert_macros.svh
`timescale 1ns / 1ps
`include "assert_macros.svh"

module d2q9_chk #(
    parameter int WORD_WIDTH = 32
) (
    input logic                         clk,
    input logic                         rst_n,
    input logic                         start,
    input logic                         busy,
    input logic                         done,
    input logic signed [WORD_WIDTH-1:0] density,
    input logic signed [WORD_WIDTH-1:0] vel_x,
    input logic signed [WORD_WIDTH-1:0] vel_y
);

    localparam int LAT = WORD_WIDTH + 14;

    logic dens_nonpos;

    assign dens_nonpos = density[WORD_WIDTH-1] || (density == '0);

    // pipeline never refuses an item
    `D2Q9_ASSERT_NEVER(chk_never_busy, busy)

    // every accepted item comes out a fixed time later
    `D2Q9_ASSERT_AFTER(chk_item_out, start && !busy, LAT, done)

    // no result without an item accepted at the right time
    `D2Q9_ASSERT_IMPLY(chk_no_phantom, done, $past(start && !busy, LAT))

    // non-positive density forces zero velocity
    `D2Q9_ASSERT_IMPLY(chk_vel_zero, done && dens_nonpos, (vel_x == '0) && (vel_y == '0))

endmodule

bind d2q9_bgk_collision_core d2q9_chk #(.WORD_WIDTH(WORD_WIDTH)) u_d2q9_chk (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (start),
    .busy    (busy),
    .done    (done),
    .density (density),
    .vel_x   (vel_x),
    .vel_y   (vel_y)
);
